/* hw/rtl/fwkr_pkg.sv */
// ----------------------------------------------------------------------------
// fwkr_pkg
// Shared types and codes for the keyed-removal queue: request and response
// payloads, slot layout, controller states and controller/datapath signals.
// ----------------------------------------------------------------------------
package fwkr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int OCC_W           = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LIST   = 2'd2;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_REMOVED   = 3'd1;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [2:0] STAT_EMPTY     = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_LISTED    = 3'd5;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] key_id;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] entry_id;
        logic signed [31:0] entry_value;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] id;
        logic signed [31:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_LIST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic adv;
        logic cmp_en;
        logic shift_en;
        logic list_en;
        logic emit_rm;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] mode;
        logic       empty;
        logic       match;
        logic       scan_done;
        logic       out_free;
    } dp_sts_t;

endpackage

/* hw/rtl/fwkr_ctrl.sv */
// ----------------------------------------------------------------------------
// fwkr_ctrl
// Sequencer for the keyed-removal queue: idle, search, compaction, listing
// and the final remove response.
// ----------------------------------------------------------------------------
module fwkr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fwkr_pkg::dp_sts_t    sts,
    output fwkr_pkg::ctrl_cmd_t  cmd
);

    fwkr_pkg::state_t state_reg;
    fwkr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwkr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fwkr_pkg::ST_IDLE:
            begin
                if (sts.accept && !sts.empty)
                begin
                    if (sts.mode == fwkr_pkg::MODE_REMOVE)
                    begin
                        state_next = fwkr_pkg::ST_SEARCH;
                    end
                    else if (sts.mode == fwkr_pkg::MODE_LIST)
                    begin
                        state_next = fwkr_pkg::ST_LIST;
                    end
                end
            end
            fwkr_pkg::ST_SEARCH:
            begin
                if (sts.match)
                begin
                    state_next = fwkr_pkg::ST_SHIFT;
                end
                else if (sts.scan_done)
                begin
                    state_next = fwkr_pkg::ST_DONE;
                end
            end
            fwkr_pkg::ST_SHIFT:
            begin
                if (sts.scan_done)
                begin
                    state_next = fwkr_pkg::ST_DONE;
                end
            end
            fwkr_pkg::ST_LIST:
            begin
                if (sts.scan_done)
                begin
                    state_next = fwkr_pkg::ST_IDLE;
                end
            end
            fwkr_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = fwkr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwkr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            fwkr_pkg::ST_IDLE:
            begin
                cmd.idle = 1'b1;
            end
            fwkr_pkg::ST_SEARCH:
            begin
                cmd.adv    = 1'b1;
                cmd.cmp_en = 1'b1;
            end
            fwkr_pkg::ST_SHIFT:
            begin
                cmd.adv      = 1'b1;
                cmd.shift_en = 1'b1;
            end
            fwkr_pkg::ST_LIST:
            begin
                cmd.adv     = sts.out_free;
                cmd.list_en = 1'b1;
            end
            fwkr_pkg::ST_DONE:
            begin
                cmd.emit_rm = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/fwkr_dp.sv */
// ----------------------------------------------------------------------------
// fwkr_dp
// Datapath of the keyed-removal queue: slot memory with registered read,
// fill count, scan pointer, id compare and the response register.
// ----------------------------------------------------------------------------
module fwkr_dp #(
    parameter int QUEUE_DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  fwkr_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output fwkr_pkg::rsp_t       rsp,
    input  fwkr_pkg::ctrl_cmd_t  cmd,
    output fwkr_pkg::dp_sts_t    sts
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    fwkr_pkg::slot_t    mem [QUEUE_DEPTH];

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_next;
    logic               rdv_reg;
    logic               rdv_next;
    logic               found_reg;
    logic               found_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    fwkr_pkg::rsp_t     rsp_reg;
    fwkr_pkg::rsp_t     rsp_next;
    logic [IW-1:0]      rd_idx_reg;
    fwkr_pkg::slot_t    rd_data_reg;
    logic signed [31:0] key_reg;

    logic               out_free;
    logic               accept;
    logic               issue;
    logic               consume;
    logic               match;
    logic               empty;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    fwkr_pkg::slot_t    wr_data;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !(cmd.idle && out_free);
    assign accept    = req_valid && !req_stall;
    assign empty     = (count_reg == '0);
    assign issue     = cmd.adv && (ptr_reg < count_reg);
    assign consume   = cmd.adv && rdv_reg;
    assign match     = cmd.cmp_en && rdv_reg && (rd_data_reg.id == key_reg);

    assign sts.accept    = accept;
    assign sts.mode      = req.mode;
    assign sts.empty     = empty;
    assign sts.match     = match;
    assign sts.scan_done = (ptr_reg >= count_reg) && !rdv_reg;
    assign sts.out_free  = out_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        rdv_next       = rdv_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        if (accept)
        begin
            ptr_next   = '0;
            rdv_next   = 1'b0;
            found_next = 1'b0;
            case (req.mode)
                fwkr_pkg::MODE_INSERT:
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        rsp_next.status    = fwkr_pkg::STAT_FULL;
                        rsp_next.occupancy = fwkr_pkg::OCC_W'(count_reg);
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = count_reg[IW-1:0];
                        wr_data.id    = req.key_id;
                        wr_data.value = req.value;
                        count_next    = count_reg + CW'(1);
                        rsp_next.status    = fwkr_pkg::STAT_INSERTED;
                        rsp_next.occupancy = fwkr_pkg::OCC_W'(count_next);
                    end
                    rsp_next.entry_id    = req.key_id;
                    rsp_next.entry_value = '0;
                    rsp_next.last        = 1'b1;
                    rsp_valid_next       = 1'b1;
                end
                fwkr_pkg::MODE_REMOVE:
                begin
                    if (empty)
                    begin
                        rsp_next.status      = fwkr_pkg::STAT_EMPTY;
                        rsp_next.entry_id    = req.key_id;
                        rsp_next.entry_value = '0;
                        rsp_next.occupancy   = '0;
                        rsp_next.last        = 1'b1;
                        rsp_valid_next       = 1'b1;
                    end
                end
                fwkr_pkg::MODE_LIST:
                begin
                    if (empty)
                    begin
                        rsp_next.status      = fwkr_pkg::STAT_EMPTY;
                        rsp_next.entry_id    = '0;
                        rsp_next.entry_value = '0;
                        rsp_next.occupancy   = '0;
                        rsp_next.last        = 1'b1;
                        rsp_valid_next       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // advance the read pipeline
            if (issue)
            begin
                ptr_next = ptr_reg + CW'(1);
                rdv_next = 1'b1;
            end
            else if (consume)
            begin
                rdv_next = 1'b0;
            end

            if (match)
            begin
                found_next = 1'b1;
            end

            // close the gap: move each later slot one place toward the head
            if (cmd.shift_en && rdv_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg - IW'(1);
                wr_data = rd_data_reg;
            end

            if (cmd.list_en && consume)
            begin
                rsp_next.status      = fwkr_pkg::STAT_LISTED;
                rsp_next.entry_id    = rd_data_reg.id;
                rsp_next.entry_value = rd_data_reg.value;
                rsp_next.occupancy   = fwkr_pkg::OCC_W'(count_reg);
                rsp_next.last        = (CW'(rd_idx_reg) == count_reg - CW'(1));
                rsp_valid_next       = 1'b1;
            end

            if (cmd.emit_rm && out_free)
            begin
                count_next           = count_reg - CW'(found_reg);
                rsp_next.status      = found_reg ? fwkr_pkg::STAT_REMOVED
                                                 : fwkr_pkg::STAT_NOT_FOUND;
                rsp_next.entry_id    = key_reg;
                rsp_next.entry_value = '0;
                rsp_next.occupancy   = fwkr_pkg::OCC_W'(count_next);
                rsp_next.last        = 1'b1;
                rsp_valid_next       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rdv_reg       <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rdv_reg       <= rdv_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            key_reg <= req.key_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[IW-1:0]];
            rd_idx_reg  <= ptr_reg[IW-1:0];
        end
    end

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.idle |-> ptr_reg <= count_reg)
        else $error("scan pointer beyond fill count");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("fill count moved by more than one");

    a_shift_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_en && rdv_reg |-> rd_idx_reg != '0)
        else $error("compaction read from the head slot");

endmodule

/* hw/rtl/fifo_with_keyed_removal.sv */
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal
// Ordered queue of (id, value) entries with insert at tail, remove by id and
// a full listing from head to tail.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_valid / req_stall / req carries mode, key_id, value.
//   Response channel rsp_valid / rsp_stall / rsp carries status, entry_id,
//   entry_value, occupancy and last; last marks the final response of a
//   request. A transfer happens on a clock edge with valid high, stall low.
//   Insert and an empty-queue remove or list finish in the accept cycle: the
//   response is valid on the next cycle, one request per cycle sustained
//   while rsp_stall is low. Remove scans the slot memory one slot per cycle,
//   then shifts later slots one per cycle, both through the single memory
//   read port, and then gives its response. List streams one response per
//   cycle from the registered memory read while rsp_stall is low. Mode 3 is
//   dropped. Requests are taken only while no other request is in progress
//   and the response register is free or being emptied.
//   A stalled response holds, and listing pauses until it is taken.
//   Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_keyed_removal #(
    parameter int QUEUE_DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  fwkr_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output fwkr_pkg::rsp_t  rsp
);

    fwkr_pkg::ctrl_cmd_t cmd;
    fwkr_pkg::dp_sts_t   sts;

    fwkr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    fwkr_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* verif/fwkr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwkr_checker
// Watches the request and response channels of the keyed-removal queue, keeps
// its own copy of the held entries, works out the responses each accepted
// request must produce and compares every accepted response field by field
// with the oldest one still due.
// ----------------------------------------------------------------------------
module fwkr_checker #(
    parameter int QUEUE_DEPTH = fwkr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  fwkr_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  fwkr_pkg::rsp_t rsp,
    output int             pending,
    output int             fail_count
);
    import fwkr_pkg::*;

    localparam int PRINT_CAP = 40;

    logic signed [31:0] held_id  [QUEUE_DEPTH];
    logic signed [31:0] held_val [QUEUE_DEPTH];
    int                 held;
    rsp_t               due_rsp [$];

    initial fail_count = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic push_rsp(input logic [2:0] st, input logic signed [31:0] id,
                            input logic signed [31:0] val, input logic lst);
        rsp_t r;
        r.status      = st;
        r.entry_id    = id;
        r.entry_value = val;
        r.occupancy   = OCC_W'(held);
        r.last        = lst;
        due_rsp.push_back(r);
    endtask

    task automatic shadow_apply(input req_t r);
        int hit;
        hit = -1;
        case (r.mode)
            MODE_INSERT:
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    push_rsp(STAT_FULL, r.key_id, '0, 1'b1);
                end
                else
                begin
                    held_id[held]  = r.key_id;
                    held_val[held] = r.value;
                    held++;
                    push_rsp(STAT_INSERTED, r.key_id, '0, 1'b1);
                end
            end
            MODE_REMOVE:
            begin
                if (held == 0)
                begin
                    push_rsp(STAT_EMPTY, r.key_id, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                        if (hit < 0 && held_id[i] == r.key_id)
                            hit = i;
                    if (hit < 0)
                    begin
                        push_rsp(STAT_NOT_FOUND, r.key_id, '0, 1'b1);
                    end
                    else
                    begin
                        for (int j = hit; j < held - 1; j++)
                        begin
                            held_id[j]  = held_id[j+1];
                            held_val[j] = held_val[j+1];
                        end
                        held--;
                        push_rsp(STAT_REMOVED, r.key_id, '0, 1'b1);
                    end
                end
            end
            MODE_LIST:
            begin
                if (held == 0)
                    push_rsp(STAT_EMPTY, '0, '0, 1'b1);
                else
                    for (int i = 0; i < held; i++)
                        push_rsp(STAT_LISTED, held_id[i], held_val[i], i == held - 1);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_rsp(input rsp_t got);
        rsp_t want;
        if (due_rsp.size() == 0)
        begin
            report_mismatch($sformatf("unexpected response status %0d id %0h",
                                      got.status, got.entry_id));
            return;
        end
        want = due_rsp.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, got.status));
        if (got.entry_id !== want.entry_id)
            report_mismatch($sformatf("entry_id expected %0h got %0h",
                                      want.entry_id, got.entry_id));
        if (got.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value expected %0h got %0h",
                                      want.entry_value, got.entry_value));
        if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy expected %0d got %0d",
                                      want.occupancy, got.occupancy));
        if (got.last !== want.last)
            report_mismatch($sformatf("last expected %0b got %0b",
                                      want.last, got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            due_rsp.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            if (req_valid && !req_stall)
                shadow_apply(req);
            pending <= due_rsp.size();
        end
    end

endmodule

/* verif/fifo_with_keyed_removal_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_keyed_removal_tb
// Drives directed and random insert, remove and list requests into the
// keyed-removal queue with random gaps on the request side and random stalls
// on the response side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module fifo_with_keyed_removal_tb;
    import fwkr_pkg::*;

    localparam logic [1:0]         MODE_UNUSED  = 2'd3;
    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 DRAIN_CYCLES = 40;
    localparam int                 RANDOM_ITEMS = 100;
    localparam logic signed [31:0] ID_MIN       = 32'sh8000_0000;
    localparam logic signed [31:0] ID_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ID_MISSING   = 32'sd7777;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int pending;
    int fail_count;
    int cycles     = 0;
    int stall_left = 0;
    int free_left  = 0;
    int pick;

    always #2 clk = ~clk;

    fifo_with_keyed_removal dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    fwkr_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            rsp_stall <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                free_left = $urandom_range(0, 3);
            else if (pick < 16)
                stall_left = $urandom_range(1, 3);
            else if (pick < 18)
                free_left = $urandom_range(20, 60);
            else
                stall_left = $urandom_range(8, 40);
            rsp_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 11);
        if (r < 8)
            return -int'($urandom_range(1, 4));
        return $urandom();
    endfunction

    task automatic send_req(input logic [1:0] m, input logic signed [31:0] k,
                            input logic signed [31:0] v, input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= req_t'{m, k, v};
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        int                 n;
        int                 gap;
        int                 r;
        logic [1:0]         m;
        logic signed [31:0] k;
        logic signed [31:0] v;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(MODE_LIST, $urandom(), $urandom(), pick_gap());
        send_req(MODE_REMOVE, ID_MIN, $urandom(), pick_gap());
        send_req(MODE_UNUSED, ID_MAX, ID_MAX, pick_gap());
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
        begin
            k = (i == 0) ? ID_MIN : (i == 1) ? ID_MAX : (i == 2) ? -32'sd1 :
                (i == 3) ? 32'sd0 : (i == 4 || i == 9) ? 32'sd5 : 32'sd100 + i;
            v = (i == 0) ? ID_MAX : (i == 1) ? ID_MIN : (i == 2) ? 32'sd0 :
                (i == 3) ? -32'sd1 : $urandom();
            send_req(MODE_INSERT, k, v, pick_gap());
        end
        send_req(MODE_INSERT, ID_MAX, ID_MIN, pick_gap());
        send_req(MODE_LIST, '0, '0, pick_gap());
        send_req(MODE_REMOVE, 32'sd5, $urandom(), pick_gap());
        send_req(MODE_REMOVE, ID_MIN, $urandom(), pick_gap());
        send_req(MODE_REMOVE, 32'sd115, $urandom(), pick_gap());
        send_req(MODE_REMOVE, ID_MISSING, $urandom(), pick_gap());
        send_req(MODE_LIST, ID_MAX, ID_MAX, pick_gap());
        wait_drained();

        // fill early, churn in the middle, refill toward full near the end
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            gap = ((n / 20) % 3 == 1) ? 0 : pick_gap();
            r   = $urandom_range(0, 99);
            k   = pick_key();
            v   = $urandom();
            if (r < 5)
            begin
                send_req(MODE_UNUSED, k, v, gap);
                continue;
            end
            if (n >= 76 && n < 94)
                m = MODE_INSERT;
            else if (r < ((n < 35) ? 65 : (n < 70) ? 35 : 45))
                m = MODE_INSERT;
            else if ($urandom_range(0, 2) != 0)
                m = MODE_REMOVE;
            else
                m = MODE_LIST;
            send_req(m, k, v, gap);
            n++;
            if (n == RANDOM_ITEMS / 2 || $urandom_range(0, 24) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/fwkr_pkg.sv
hw/rtl/fwkr_ctrl.sv
hw/rtl/fwkr_dp.sv
hw/rtl/fifo_with_keyed_removal.sv
verif/fwkr_checker.sv
verif/fifo_with_keyed_removal_tb.sv
